### rtl/core/rabg_pkg.sv
// Package for the rational arithmetic unit with binary GCD reduction.
// Holds command and status codes, payload structs and the front-to-back job type.
package rabg_pkg;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_EQ  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               is_equal;
    logic [1:0]         status;
  } out_item_t;

  // Job handed from the front to the back: one or two fractions to reduce.
  typedef struct packed {
    logic               is_eq;
    logic [1:0]         status;
    logic signed [31:0] n0;
    logic signed [31:0] d0;
    logic signed [31:0] n1;
    logic signed [31:0] d1;
  } job_t;

endpackage

### rtl/core/rational_arith_binary_gcd.sv
// Top level of the rational arithmetic unit with binary GCD reduction.
// Depends on rabg_pkg, rabg_front, rabg_queue and rabg_back.
//
// Usage: the in_ channel takes one transaction holding a command and two
// fractions; the out_ channel returns one result transaction for each,
// in order. Both use valid/ready handshakes.
// The front end forms cross products with one shared 32x32 multiplier,
// checks zero denominators and overflow, and pushes a job into a two-entry
// queue. The back end runs the binary GCD, one shift or subtract per cycle,
// then divides both magnitudes by the GCD with a restoring divider.
// The equality command reduces two fractions. The back end takes a new job
// only after it has returned the result of the last one.
// Reset is synchronous and clears all control state; no clearing pass.
// When out_ready is low the result holds on out_data, while the front end
// keeps filling the queue and then stalls in_ready.
module rational_arith_binary_gcd import rabg_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  rabg_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  rabg_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  rabg_back u_back (
    .clk, .rst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .out_data
  );

  // An error result carries zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.res_num == '0 && out_data.res_den == '0 && !out_data.is_equal)
    else $error("error result with nonzero fields");

  // A successful result with a nonzero numerator never has a zero denominator.
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK && out_data.res_num != '0 |->
      out_data.res_den != '0)
    else $error("zero denominator on ok result");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

### rtl/core/rabg_front.sv
// Front end: accepts transactions, forms cross products, classifies errors.
// Depends on rabg_pkg.
module rabg_front import rabg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL0 = 3'd1;
  localparam logic [2:0] F_MUL1 = 3'd2;
  localparam logic [2:0] F_MUL2 = 3'd3;
  localparam logic [2:0] F_SUM  = 3'd4;
  localparam logic [2:0] F_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  in_item_t   item_r;
  logic signed [63:0] p_r, q_r, d_r;
  logic signed [63:0] prod;
  logic signed [31:0] mx, my;
  logic       zerr;
  job_t       job_r;

  function automatic logic fits(input logic signed [63:0] v);
    fits = (v[63:31] == {33{v[31]}});
  endfunction

  assign in_ready  = (state_r == F_IDLE);
  assign job_valid = (state_r == F_OUT);
  assign job       = job_r;

  // One 32x32 multiplier shared by the F_MUL0, F_MUL1 and F_MUL2 states.
  always_comb begin
    mx = item_r.a_num;
    my = item_r.b_den;
    unique case (state_r)
      F_MUL0: begin
        mx = item_r.a_num;
        my = (item_r.cmd == CMD_MUL) ? item_r.b_num : item_r.b_den;
      end
      F_MUL1: begin
        mx = item_r.a_den;
        my = (item_r.cmd == CMD_DIV) ? item_r.b_num : item_r.b_den;
      end
      F_MUL2: begin
        mx = item_r.b_num;
        my = item_r.a_den;
      end
      default: begin
        mx = item_r.a_num;
        my = item_r.b_den;
      end
    endcase
    prod = 64'(mx) * 64'(my);
  end

  assign zerr = (item_r.cmd > CMD_EQ) || (item_r.a_den == 32'sd0) ||
                (item_r.b_den == 32'sd0) ||
                ((item_r.cmd == CMD_DIV) && (item_r.b_num == 32'sd0));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_MUL0;
      F_MUL0: state_nxt = F_MUL1;
      F_MUL1: state_nxt = (item_r.cmd <= CMD_SUB) ? F_MUL2 : F_SUM;
      F_MUL2: state_nxt = F_SUM;
      F_SUM:  state_nxt = F_OUT;
      F_OUT:  if (job_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload and product registers.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) item_r <= in_data;
    if (state_r == F_MUL0) p_r <= prod;
    if (state_r == F_MUL1) d_r <= prod;
    if (state_r == F_MUL2) q_r <= prod;
    if (state_r == F_SUM) begin
      job_r.n1 <= item_r.b_num;
      job_r.d1 <= item_r.b_den;
      job_r.is_eq <= 1'b0;
      job_r.status <= ST_OK;
      job_r.n0 <= p_r[31:0];
      job_r.d0 <= d_r[31:0];
      if (zerr) begin
        job_r.status <= ST_ZERO;
      end else if (item_r.cmd == CMD_EQ) begin
        job_r.is_eq <= 1'b1;
        job_r.n0 <= item_r.a_num;
        job_r.d0 <= item_r.a_den;
      end else if (item_r.cmd <= CMD_SUB) begin
        if (!fits(p_r) || !fits(q_r) || !fits(d_r)) begin
          job_r.status <= ST_OVF;
        end else begin
          logic signed [32:0] s;
          s = (item_r.cmd == CMD_ADD) ?
              (33'($signed(p_r[31:0])) + 33'($signed(q_r[31:0]))) :
              (33'($signed(p_r[31:0])) - 33'($signed(q_r[31:0])));
          if (s[32] != s[31]) job_r.status <= ST_OVF;
          job_r.n0 <= s[31:0];
        end
      end else begin
        if (!fits(p_r) || !fits(d_r)) job_r.status <= ST_OVF;
      end
    end
  end

endmodule

### rtl/core/rabg_queue.sv
// Short job queue between the front and back ends.
// Depends on rabg_pkg.
module rabg_queue import rabg_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

### rtl/core/rabg_back.sv
// Back end: binary GCD reduction and restoring division by the GCD, one step a cycle.
// Depends on rabg_pkg.
module rabg_back import rabg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_LOAD  = 3'd1;
  localparam logic [2:0] B_SHK   = 3'd2;
  localparam logic [2:0] B_LOOP  = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_NEXT  = 3'd5;
  localparam logic [2:0] B_OUT   = 3'd6;

  logic [2:0]  state_r;
  job_t        job_r;
  logic        pass_r;            // 0: first fraction, 1: second
  logic [31:0] u_r, v_r, g_r;
  logic [4:0]  k_r;
  logic [31:0] rn_r, rd_r, an_r, ad_r;
  logic [5:0]  bit_r;
  logic signed [31:0] xn_r, xd_r, yn_r, yd_r;
  logic        zero_r;
  out_item_t   out_r;
  logic signed [31:0] cur_n, cur_d;
  logic [31:0] mn, md;
  logic [32:0] trn, trd;

  assign job_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_data  = out_r;

  assign cur_n = pass_r ? job_r.n1 : job_r.n0;
  assign cur_d = pass_r ? job_r.d1 : job_r.d0;
  assign mn = cur_n[31] ? (32'd0 - 32'(cur_n)) : 32'(cur_n);
  assign md = cur_d[31] ? (32'd0 - 32'(cur_d)) : 32'(cur_d);
  assign trn = {rn_r, an_r[31]} - {1'b0, g_r};
  assign trd = {rd_r, ad_r[31]} - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE: if (job_valid) begin
          job_r <= job;
          pass_r <= 1'b0;
          state_r <= (job.status != ST_OK) ? B_NEXT : B_LOAD;
        end
        B_LOAD: begin
          u_r <= mn;
          v_r <= md;
          k_r <= '0;
          an_r <= mn;
          ad_r <= md;
          zero_r <= (cur_n == 32'sd0);
          state_r <= (cur_n == 32'sd0) ? B_NEXT : B_SHK;
        end
        // Strip common factors of two, then make u odd.
        B_SHK: begin
          if (((u_r | v_r) & 32'd1) == 32'd0 && k_r != 5'd31) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 5'd1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else begin
            state_r <= B_LOOP;
          end
        end
        // Stein step: strip v's twos, else swap-and-subtract.
        B_LOOP: begin
          if (v_r == 32'd0) begin
            g_r <= u_r << k_r;
            rn_r <= '0;
            rd_r <= '0;
            bit_r <= 6'd32;
            state_r <= B_DIV;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r > v_r) begin
            u_r <= v_r;
            v_r <= u_r - v_r;
          end else begin
            v_r <= v_r - u_r;
          end
        end
        // Restoring division of both magnitudes by the GCD.
        B_DIV: begin
          if (bit_r == 6'd0) begin
            state_r <= B_NEXT;
          end else begin
            if (!trn[32]) rn_r <= trn[31:0]; else rn_r <= {rn_r[30:0], an_r[31]};
            if (!trd[32]) rd_r <= trd[31:0]; else rd_r <= {rd_r[30:0], ad_r[31]};
            an_r <= {an_r[30:0], !trn[32]};
            ad_r <= {ad_r[30:0], !trd[32]};
            bit_r <= bit_r - 6'd1;
          end
        end
        B_NEXT: begin
          if (pass_r) begin
            yn_r <= zero_r ? 32'sd0 : (cur_n[31] ? -$signed(an_r) : $signed(an_r));
            yd_r <= zero_r ? 32'sd1 : (cur_d[31] ? -$signed(ad_r) : $signed(ad_r));
          end else begin
            xn_r <= zero_r ? 32'sd0 : (cur_n[31] ? -$signed(an_r) : $signed(an_r));
            xd_r <= zero_r ? 32'sd1 : (cur_d[31] ? -$signed(ad_r) : $signed(ad_r));
          end
          if (job_r.status == ST_OK && job_r.is_eq && !pass_r) begin
            pass_r <= 1'b1;
            state_r <= B_LOAD;
          end else begin
            state_r <= B_OUT;
          end
        end
        B_OUT: if (out_ready) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Assemble the result combinationally from the job status and reduced fractions.
  always_comb begin
    out_r = '0;
    out_r.status = job_r.status;
    if (job_r.status == ST_OK) begin
      if (job_r.is_eq) begin
        out_r.is_equal = (xn_r == yn_r) && (xd_r == yd_r);
      end else begin
        out_r.res_num = xn_r;
        out_r.res_den = xd_r;
      end
    end
  end

endmodule
